// ===== rtl/adsr_envelope_level_assert.svh =====
// Assertion macros for the envelope level block.
`ifndef ADSR_ENVELOPE_LEVEL_ASSERT_SVH
`define ADSR_ENVELOPE_LEVEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adsr_pkg.sv =====
// Shared constants and types of the envelope level block.
package adsr_pkg;

    // Default parameter values.
    localparam int ADSR_TIME_BITS = 32;
    localparam int ADSR_FRAC_BITS = 15;

    // Field and register widths.
    localparam int ADSR_TICK_W      = 18;
    localparam int ADSR_LVL_W       = 16;
    localparam int ADSR_TIME_W      = 32;
    localparam int ADSR_IN_TDATA_W  = 96;
    localparam int ADSR_OUT_TDATA_W = 24;
    localparam int ADSR_CFG_IDX_W   = 3;
    localparam int ADSR_CFG_DATA_W  = 18;

    // Levels at or below one ten-thousandth of full scale are cut to zero.
    localparam int ADSR_FLOOR_DIV = 10000;

    // Register values after reset.
    localparam logic [ADSR_TICK_W-1:0] ADSR_RST_ATTACK  = 18'd4800;
    localparam logic [ADSR_TICK_W-1:0] ADSR_RST_DECAY   = 18'd0;
    localparam logic [ADSR_TICK_W-1:0] ADSR_RST_RELEASE = 18'd24000;
    localparam logic [ADSR_LVL_W-1:0]  ADSR_RST_START   = 16'd32768;
    localparam logic [ADSR_LVL_W-1:0]  ADSR_RST_SUSTAIN = 16'd32768;

    // Configuration register indexes.
    typedef enum logic [ADSR_CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_START   = 3'd3,
        CFG_SUSTAIN = 3'd4
    } t_cfg_idx;

endpackage

// ===== rtl/adsr_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module adsr_div
    import adsr_pkg::*;
#(
    parameter int DW  = ADSR_TICK_W,
    parameter int QW  = ADSR_LVL_W,
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [SBW-1:0]   i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [SBW-1:0]   o_side
);

    localparam int NW = DW + QW;

    // Stage registers; the numerator is known to be below den * 2^QW.
    logic [QW-1:0]  r_vld;
    logic [NW-1:0]  r_rem  [QW];
    logic [DW-1:0]  r_den  [QW];
    logic [QW-1:0]  r_quo  [QW];
    logic [SBW-1:0] r_side [QW];

    logic [QW-1:0]  w_vld_in;
    logic [NW-1:0]  w_rem_in  [QW];
    logic [DW-1:0]  w_den_in  [QW];
    logic [QW-1:0]  w_quo_in  [QW];
    logic [SBW-1:0] w_side_in [QW];
    logic [NW-1:0]  n_rem [QW];
    logic [QW-1:0]  n_quo [QW];

    // Each stage tries to subtract the divisor shifted to its quotient bit.
    for (genvar s = 0; s < QW; s++) begin : g_bit
        localparam int SH = QW - 1 - s;
        logic [NW-1:0] w_den_sh;
        logic          w_fit;

        if (s == 0) begin : g_head
            assign w_vld_in[s]  = i_valid;
            assign w_rem_in[s]  = i_num;
            assign w_den_in[s]  = i_den;
            assign w_quo_in[s]  = '0;
            assign w_side_in[s] = i_side;
        end else begin : g_tail
            assign w_vld_in[s]  = r_vld[s-1];
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_den_in[s]  = r_den[s-1];
            assign w_quo_in[s]  = r_quo[s-1];
            assign w_side_in[s] = r_side[s-1];
        end

        assign w_den_sh = NW'(w_den_in[s]) << SH;
        assign w_fit    = (w_rem_in[s] >= w_den_sh);
        assign n_rem[s] = w_fit ? (w_rem_in[s] - w_den_sh) : w_rem_in[s];
        assign n_quo[s] = w_quo_in[s] | (QW'(w_fit) << SH);
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= w_vld_in;
        end
    end

    // Payload advances whenever the pipeline does.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= w_den_in[s];
                r_quo[s]  <= n_quo[s];
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/adsr_envelope_level.sv =====
// Envelope level pipeline: one ADSR level per transaction, one transaction per cycle
// while the output buffer has a free entry. The path holds 2*Q+6 register stages,
// Q = min(LEVEL_FRAC_BITS+1, 16); the two Q-stage dividers are fully pipelined.
// A two-entry output buffer keeps s_axis_tready registered; it drops only when both are full.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
`include "adsr_envelope_level_assert.svh"

module adsr_envelope_level
    import adsr_pkg::*;
#(
    parameter int TIME_BITS       = ADSR_TIME_BITS,
    parameter int LEVEL_FRAC_BITS = ADSR_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ADSR_IN_TDATA_W-1:0]  s_axis_tdata,  // now_time, on_time, off_time
    // Output stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ADSR_OUT_TDATA_W-1:0] m_axis_tdata,  // level, finished, zero pad
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [ADSR_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ADSR_CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TK = ADSR_TICK_W;
    localparam int TW = (TIME_BITS < ADSR_TIME_W) ? TIME_BITS : ADSR_TIME_W;
    localparam int CW = (TW > TK + 1) ? TW : TK + 1;
    localparam int SW = (LEVEL_FRAC_BITS + 1 < ADSR_LVL_W) ? LEVEL_FRAC_BITS + 1 : ADSR_LVL_W;
    localparam int NW = TK + SW;
    localparam int PAD_W = ADSR_OUT_TDATA_W - ADSR_LVL_W - 1;
    localparam logic [31:0] LEVEL_ONE   = 32'd1 << LEVEL_FRAC_BITS;
    localparam logic [31:0] LEVEL_FLOOR = LEVEL_ONE / ADSR_FLOOR_DIV;

    // Sideband carried through the held-curve divider.
    typedef struct packed {
        logic          cst;
        logic          sub;
        logic [SW-1:0] base;
        logic          held;
        logic          rel;
        logic          rzero;
        logic [TK-1:0] rt;
    } t_side1;

    // Sideband carried through the release divider.
    typedef struct packed {
        logic [SW-1:0] hlev;
        logic          held;
        logic          rel;
        logic          rzero;
    } t_side2;

    // Configuration registers.
    logic [TK-1:0]         r_attack_ticks;
    logic [TK-1:0]         r_decay_ticks;
    logic [TK-1:0]         r_release_ticks;
    logic [ADSR_LVL_W-1:0] r_start_level;
    logic [ADSR_LVL_W-1:0] r_sustain_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_ticks  <= ADSR_RST_ATTACK;
            r_decay_ticks   <= ADSR_RST_DECAY;
            r_release_ticks <= ADSR_RST_RELEASE;
            r_start_level   <= ADSR_RST_START;
            r_sustain_level <= ADSR_RST_SUSTAIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ATTACK:  r_attack_ticks  <= i_cfg_data[TK-1:0];
                CFG_DECAY:   r_decay_ticks   <= i_cfg_data[TK-1:0];
                CFG_RELEASE: r_release_ticks <= i_cfg_data[TK-1:0];
                CFG_START:   r_start_level   <= i_cfg_data[ADSR_LVL_W-1:0];
                CFG_SUSTAIN: r_sustain_level <= i_cfg_data[ADSR_LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Levels above full scale saturate to full scale.
    logic [SW-1:0] w_s0;
    logic [SW-1:0] w_s1;
    logic          w_up;
    logic [SW-1:0] w_diff;

    assign w_s0   = (32'(r_start_level) > LEVEL_ONE) ? SW'(LEVEL_ONE) : SW'(r_start_level);
    assign w_s1   = (32'(r_sustain_level) > LEVEL_ONE) ? SW'(LEVEL_ONE) : SW'(r_sustain_level);
    assign w_up   = (w_s1 >= w_s0);
    assign w_diff = w_up ? (w_s1 - w_s0) : (w_s0 - w_s1);

    // The whole pipeline moves while the output buffer has a free entry.
    logic w_adv;
    logic r_out_vld;
    logic r_skid_vld;

    assign w_adv         = !r_skid_vld;
    assign s_axis_tready = w_adv;

    // Stage 1: time differences and note state.
    logic [TW-1:0] w_now;
    logic [TW-1:0] w_on;
    logic [TW-1:0] w_off;
    logic          r_s1_vld;
    logic          r_s1_held;
    logic          r_s1_before;
    logic          r_s1_rel;
    logic [TW-1:0] r_s1_life;
    logic [TW-1:0] r_s1_t;

    assign w_now = s_axis_tdata[TW-1:0];
    assign w_on  = s_axis_tdata[ADSR_TIME_W +: TW];
    assign w_off = s_axis_tdata[2*ADSR_TIME_W +: TW];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_held   <= (w_on > w_off);
            r_s1_before <= (w_now < w_on);
            r_s1_rel    <= (w_off > w_on);
            r_s1_life   <= (w_on > w_off) ? (w_now - w_on) : (w_off - w_on);
            r_s1_t      <= (w_now > w_off) ? (w_now - w_off) : '0;
        end
    end

    // Stage 2: pick the curve segment and set up the first multiply-divide.
    logic [CW-1:0] w_s2_life;
    logic [CW-1:0] w_s2_a;
    logic [CW-1:0] w_s2_t;
    logic          w_s2_in_attack;
    logic          w_s2_in_decay;
    logic [TK-1:0] w_s2_dt;
    logic          w_s2_rzero;
    logic [TK-1:0] w_s2_rt;
    t_side1        n_s2_side;
    logic [TK-1:0] n_s2_den;
    logic [TK-1:0] n_s2_mul_a;
    logic [SW-1:0] n_s2_mul_b;
    logic          r_s2_vld;
    t_side1        r_s2_side;
    logic [TK-1:0] r_s2_den;
    logic [TK-1:0] r_s2_mul_a;
    logic [SW-1:0] r_s2_mul_b;

    assign w_s2_life      = CW'(r_s1_life);
    assign w_s2_a         = CW'(r_attack_ticks);
    assign w_s2_t         = CW'(r_s1_t);
    assign w_s2_in_attack = (w_s2_life <= w_s2_a);
    assign w_s2_in_decay  = (w_s2_life <= (w_s2_a + CW'(r_decay_ticks)));
    assign w_s2_dt        = TK'(w_s2_life - w_s2_a);
    assign w_s2_rzero     = (r_release_ticks == '0) || (w_s2_t >= CW'(r_release_ticks));
    assign w_s2_rt        = TK'(CW'(r_release_ticks) - w_s2_t);

    always_comb begin
        n_s2_side.cst   = 1'b1;
        n_s2_side.sub   = 1'b0;
        n_s2_side.base  = w_s1;
        n_s2_side.held  = r_s1_held;
        n_s2_side.rel   = r_s1_rel;
        n_s2_side.rzero = w_s2_rzero;
        n_s2_side.rt    = w_s2_rt;
        n_s2_den        = r_decay_ticks;
        n_s2_mul_a      = '0;
        n_s2_mul_b      = '0;
        if (r_s1_held && r_s1_before) begin
            // Note not yet triggered.
            n_s2_side.base = '0;
        end else if (w_s2_in_attack) begin
            if (r_attack_ticks == '0) begin
                // Zero attack time jumps straight to the start level.
                n_s2_side.base = w_s0;
            end else begin
                n_s2_side.cst  = 1'b0;
                n_s2_side.base = '0;
                n_s2_mul_a     = TK'(r_s1_life);
                n_s2_mul_b     = w_s0;
                n_s2_den       = r_attack_ticks;
            end
        end else if (w_s2_in_decay) begin
            n_s2_side.cst  = 1'b0;
            n_s2_side.sub  = !w_up;
            n_s2_side.base = w_s0;
            n_s2_mul_a     = w_s2_dt;
            n_s2_mul_b     = w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_side  <= n_s2_side;
            r_s2_den   <= n_s2_den;
            r_s2_mul_a <= n_s2_mul_a;
            r_s2_mul_b <= n_s2_mul_b;
        end
    end

    // Stage 3: product for the held-curve division.
    logic          r_s3_vld;
    logic [NW-1:0] r_s3_prod;
    logic [TK-1:0] r_s3_den;
    t_side1        r_s3_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_prod <= NW'(r_s2_mul_a) * NW'(r_s2_mul_b);
            r_s3_den  <= r_s2_den;
            r_s3_side <= r_s2_side;
        end
    end

    // Held-curve divider.
    logic          w_d1_vld;
    logic [SW-1:0] w_d1_quo;
    t_side1        w_d1_side;

    adsr_div #(
        .DW  (TK),
        .QW  (SW),
        .SBW ($bits(t_side1))
    ) u_div_held (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_prod),
        .i_den   (r_s3_den),
        .i_side  (r_s3_side),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    // Stage 4: level on the held curve.
    logic [SW-1:0] n_s4_hlev;
    logic          r_s4_vld;
    logic [SW-1:0] r_s4_hlev;
    logic          r_s4_held;
    logic          r_s4_rel;
    logic          r_s4_rzero;
    logic [TK-1:0] r_s4_rt;

    always_comb begin
        if (w_d1_side.cst) begin
            n_s4_hlev = w_d1_side.base;
        end else if (w_d1_side.sub) begin
            n_s4_hlev = w_d1_side.base - w_d1_quo;
        end else begin
            n_s4_hlev = w_d1_side.base + w_d1_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_hlev  <= n_s4_hlev;
            r_s4_held  <= w_d1_side.held;
            r_s4_rel   <= w_d1_side.rel;
            r_s4_rzero <= w_d1_side.rzero;
            r_s4_rt    <= w_d1_side.rt;
        end
    end

    // Stage 5: product for the release division.
    logic          r_s5_vld;
    logic [NW-1:0] r_s5_prod;
    t_side2        r_s5_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_prod       <= NW'(r_s4_hlev) * NW'(r_s4_rt);
            r_s5_side.hlev  <= r_s4_hlev;
            r_s5_side.held  <= r_s4_held;
            r_s5_side.rel   <= r_s4_rel;
            r_s5_side.rzero <= r_s4_rzero;
        end
    end

    // Release divider.
    logic          w_d2_vld;
    logic [SW-1:0] w_d2_quo;
    t_side2        w_d2_side;

    adsr_div #(
        .DW  (TK),
        .QW  (SW),
        .SBW ($bits(t_side2))
    ) u_div_release (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s5_vld),
        .i_num   (r_s5_prod),
        .i_den   (r_release_ticks),
        .i_side  (r_s5_side),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    // Final level: choose held or released value, apply the floor.
    logic [SW-1:0]               w_raw;
    logic [SW-1:0]               w_level;
    logic                        w_fin;
    logic [ADSR_OUT_TDATA_W-1:0] w_res;
    logic                        w_push;
    logic                        w_pop;

    assign w_raw   = w_d2_side.held ? w_d2_side.hlev : (w_d2_side.rzero ? '0 : w_d2_quo);
    assign w_level = (32'(w_raw) <= LEVEL_FLOOR) ? '0 : w_raw;
    assign w_fin   = (w_level == '0) && w_d2_side.rel;
    assign w_res   = {{PAD_W{1'b0}}, w_fin, ADSR_LVL_W'(w_level)};
    assign w_push  = w_adv && w_d2_vld;
    assign w_pop   = r_out_vld && m_axis_tready;

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= w_d1_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    // Two-entry output buffer: head register plus one skid entry.
    logic [ADSR_OUT_TDATA_W-1:0] r_out_data;
    logic [ADSR_OUT_TDATA_W-1:0] r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_push;
                r_out_data <= w_res;
            end
        end else if (w_push) begin
            if (r_out_vld) begin
                r_skid_vld  <= 1'b1;
                r_skid_data <= w_res;
            end else begin
                r_out_vld  <= 1'b1;
                r_out_data <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Checks on the output buffer and the result encoding.
    `ADSR_ASSERT_IMPL(a_skid_order, r_skid_vld, r_out_vld, "skid entry valid while head is empty")
    `ADSR_ASSERT_NEXT(a_skid_hold, r_skid_vld && !m_axis_tready, r_skid_vld, "skid entry lost while stalled")
    `ADSR_ASSERT_IMPL(a_lvl_floor, m_axis_tvalid, (32'(m_axis_tdata[ADSR_LVL_W-1:0]) == 32'd0) || (32'(m_axis_tdata[ADSR_LVL_W-1:0]) > LEVEL_FLOOR), "level below floor not cut to zero")
    `ADSR_ASSERT_IMPL(a_fin_zero, m_axis_tvalid && m_axis_tdata[ADSR_LVL_W], m_axis_tdata[ADSR_LVL_W-1:0] == '0, "finished flag with nonzero level")

endmodule

// ===== tb/adsr_envelope_level_tb.sv =====
// Self-checking testbench for the ADSR envelope level pipeline.
module adsr_envelope_level_tb
    import adsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Envelope arithmetic constants at the default configuration.
    localparam logic [63:0] LEVEL_ONE   = 64'd1 << ADSR_FRAC_BITS;
    localparam logic [63:0] LEVEL_FLOOR = LEVEL_ONE / ADSR_FLOOR_DIV;
    localparam logic [ADSR_TICK_W-1:0] TICKS_MAX = '1;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PIPE_LATENCY    = 38;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 120;

    // One envelope result as it appears on the output stream.
    typedef struct packed {
        logic                  finished;
        logic [ADSR_LVL_W-1:0] level;
    } t_envelope;

    // One row of the directed stimulus table.
    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind             kind;
        t_cfg_idx               idx;
        logic [ADSR_TICK_W-1:0] value;
        logic [ADSR_TIME_W-1:0] now_t;
        logic [ADSR_TIME_W-1:0] on_t;
        logic [ADSR_TIME_W-1:0] off_t;
        logic                   fixed;
        t_envelope              result;
    } t_step;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [ADSR_IN_TDATA_W-1:0]  s_axis_tdata;   // now_time, on_time, off_time
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [ADSR_OUT_TDATA_W-1:0] m_axis_tdata;   // level, finished, zero pad
    logic                        i_cfg_we;
    logic [ADSR_CFG_IDX_W-1:0]   i_cfg_idx;
    logic [ADSR_CFG_DATA_W-1:0]  i_cfg_data;

    // Local copy of the envelope registers.
    logic [ADSR_TICK_W-1:0] attack_ticks;
    logic [ADSR_TICK_W-1:0] decay_ticks;
    logic [ADSR_TICK_W-1:0] release_ticks;
    logic [ADSR_LVL_W-1:0]  start_level;
    logic [ADSR_LVL_W-1:0]  sustain_level;

    t_envelope   levels_due[$];
    t_step       directed_steps[$];
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned settings_used;
    int unsigned directed_items;
    t_envelope   seen_envelope;
    t_envelope   due_envelope;

    adsr_envelope_level u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, levels_due.size());
        $display("Mismatches found");
        $finish;
    end

    // Receiver back-pressure, changed at the falling edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // Level of the held-note curve after life ticks, with level registers saturated.
    function automatic logic [63:0] held_level(input logic [63:0] life);
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] s0;
        logic [63:0] s1;
        a  = attack_ticks;
        d  = decay_ticks;
        s0 = (start_level > LEVEL_ONE) ? LEVEL_ONE : 64'(start_level);
        s1 = (sustain_level > LEVEL_ONE) ? LEVEL_ONE : 64'(sustain_level);
        if (life <= a) begin
            return (a == 0) ? s0 : (life * s0) / a;
        end
        if (life <= a + d) begin
            if (s1 >= s0) begin
                return s0 + ((life - a) * (s1 - s0)) / d;
            end
            return s0 - ((life - a) * (s0 - s1)) / d;
        end
        return s1;
    endfunction

    // Envelope level and finished flag for one set of times.
    function automatic t_envelope envelope_at(input logic [ADSR_TIME_W-1:0] now_t,
                                              input logic [ADSR_TIME_W-1:0] on_t,
                                              input logic [ADSR_TIME_W-1:0] off_t);
        logic [63:0] lvl;
        logic [63:0] held;
        logic [63:0] since_off;
        logic [63:0] r;
        t_envelope   env;
        if (on_t > off_t) begin
            lvl = (now_t < on_t) ? 64'd0 : held_level(64'(now_t - on_t));
        end else begin
            held      = held_level(64'(off_t - on_t));
            since_off = (now_t > off_t) ? 64'(now_t - off_t) : 64'd0;
            r         = release_ticks;
            if (r == 0 || since_off >= r) begin
                lvl = 0;
            end else begin
                lvl = (held * (r - since_off)) / r;
            end
        end
        if (lvl <= LEVEL_FLOOR) begin
            lvl = 0;
        end
        env.level    = lvl[ADSR_LVL_W-1:0];
        env.finished = (lvl == 0) && (off_t > on_t);
        return env;
    endfunction

    // Write one register; called and returning at a falling edge.
    task automatic cfg_write(input t_cfg_idx idx, input logic [ADSR_TICK_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ATTACK:  attack_ticks  = value;
            CFG_DECAY:   decay_ticks   = value;
            CFG_RELEASE: release_ticks = value;
            CFG_START:   start_level   = value[ADSR_LVL_W-1:0];
            CFG_SUSTAIN: sustain_level = value[ADSR_LVL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Hold the input stream idle until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Offer one transaction; the expected result is queued when it is accepted.
    task automatic send_item(input logic [ADSR_TIME_W-1:0] now_t,
                             input logic [ADSR_TIME_W-1:0] on_t,
                             input logic [ADSR_TIME_W-1:0] off_t,
                             input logic                   fixed,
                             input t_envelope              fixed_result);
        t_envelope due;
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off_t, on_t, now_t};
        do @(posedge i_clk); while (!s_axis_tready);
        due        = fixed ? fixed_result : envelope_at(now_t, on_t, off_t);
        levels_due = {levels_due, due};
        items_sent++;
        @(negedge i_clk);
    endtask

    // Directed table builders.
    task automatic add_item(input logic [ADSR_TIME_W-1:0] now_t,
                            input logic [ADSR_TIME_W-1:0] on_t,
                            input logic [ADSR_TIME_W-1:0] off_t);
        t_step row;
        row        = '0;
        row.kind   = STEP_ITEM;
        row.now_t  = now_t;
        row.on_t   = on_t;
        row.off_t  = off_t;
        directed_steps = {directed_steps, row};
    endtask

    task automatic add_known(input logic [ADSR_TIME_W-1:0] now_t,
                             input logic [ADSR_TIME_W-1:0] on_t,
                             input logic [ADSR_TIME_W-1:0] off_t,
                             input logic [ADSR_LVL_W-1:0]  lvl,
                             input logic                   done);
        t_step row;
        row                 = '0;
        row.kind            = STEP_ITEM;
        row.now_t           = now_t;
        row.on_t            = on_t;
        row.off_t           = off_t;
        row.fixed           = 1'b1;
        row.result.level    = lvl;
        row.result.finished = done;
        directed_steps = {directed_steps, row};
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [ADSR_TICK_W-1:0] value);
        t_step row;
        row       = '0;
        row.kind  = STEP_CFG;
        row.idx   = idx;
        row.value = value;
        directed_steps = {directed_steps, row};
    endtask

    // Random register values, biased toward the extremes.
    function automatic logic [ADSR_TICK_W-1:0] pick_ticks();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return TICKS_MAX;
            2: return ADSR_TICK_W'($urandom_range(64, 1));
            3: return ADSR_TICK_W'($urandom_range(5000, 0));
            default: return ADSR_TICK_W'($urandom_range(TICKS_MAX, 0));
        endcase
    endfunction

    function automatic logic [ADSR_LVL_W-1:0] pick_level();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return ADSR_LVL_W'(LEVEL_ONE);
            2: return '1;
            3: return ADSR_LVL_W'($urandom_range(65535, 32769));
            default: return ADSR_LVL_W'($urandom_range(32768, 0));
        endcase
    endfunction

    // Lifetime offsets aimed at the attack, decay and sustain segments.
    function automatic logic [ADSR_TIME_W-1:0] pick_life();
        logic [ADSR_TIME_W-1:0] a;
        logic [ADSR_TIME_W-1:0] d;
        a = attack_ticks;
        d = decay_ticks;
        case ($urandom_range(5, 0))
            0: return $urandom_range(2, 0);
            1: return $urandom_range(a, 0);
            2: return a + $urandom_range(d, 0);
            3: return a + d + $urandom_range(100, 0);
            4: return $urandom_range(32'hFFFF, 0);
            default: return $urandom;
        endcase
    endfunction

    // Ticks after release, aimed at the ramp, its end and the zero floor.
    function automatic logic [ADSR_TIME_W-1:0] pick_after_release();
        logic [ADSR_TIME_W-1:0] r;
        r = release_ticks;
        case ($urandom_range(4, 0))
            0: return '0;
            1: return $urandom_range(r, 0);
            2: return r - $urandom_range(3, 0);
            3: return r + $urandom_range(100, 0);
            default: return $urandom;
        endcase
    endfunction

    // One random transaction: mostly held or released notes, some pure noise.
    task automatic send_random_item();
        logic [ADSR_TIME_W-1:0] now_t;
        logic [ADSR_TIME_W-1:0] on_t;
        logic [ADSR_TIME_W-1:0] off_t;
        int unsigned            kind;
        kind = $urandom_range(99, 0);
        if (kind < 10) begin
            now_t = $urandom;
            on_t  = $urandom;
            off_t = $urandom;
        end else if (kind < 55) begin
            on_t  = $urandom_range(32'hFFFF_0000, 1);
            off_t = $urandom_range(on_t - 1, 0);
            if ($urandom_range(9, 0) == 0) begin
                now_t = on_t - $urandom_range(500, 1);
            end else begin
                now_t = on_t + pick_life();
            end
        end else begin
            on_t  = $urandom_range(32'hF000_0000, 0);
            off_t = on_t + pick_life();
            if ($urandom_range(9, 0) == 0) begin
                now_t = off_t - $urandom_range(500, 0);
            end else begin
                now_t = off_t + pick_after_release();
            end
        end
        send_item(now_t, on_t, off_t, 1'b0, '0);
    endtask

    // Output check: each transaction against the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_envelope.level    = m_axis_tdata[ADSR_LVL_W-1:0];
            seen_envelope.finished = m_axis_tdata[ADSR_LVL_W];
            results_seen++;
            if (levels_due.size() == 0) begin
                $display("%0t: unexpected result level=%0d finished=%0d", $time,
                         seen_envelope.level, seen_envelope.finished);
                mismatch_count++;
            end else begin
                due_envelope = levels_due.pop_front();
                if (seen_envelope.level !== due_envelope.level) begin
                    $display("%0t: level expected %0d actual %0d", $time,
                             due_envelope.level, seen_envelope.level);
                    mismatch_count++;
                end
                if (seen_envelope.finished !== due_envelope.finished) begin
                    $display("%0t: finished expected %0d actual %0d", $time,
                             due_envelope.finished, seen_envelope.finished);
                    mismatch_count++;
                end
            end
        end
    end

    // Main stimulus sequence.
    initial begin
        i_rst_n            = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        items_sent         = 0;
        results_seen       = 0;
        settings_used      = 1;
        attack_ticks       = ADSR_RST_ATTACK;
        decay_ticks        = ADSR_RST_DECAY;
        release_ticks      = ADSR_RST_RELEASE;
        start_level        = ADSR_RST_START;
        sustain_level      = ADSR_RST_SUSTAIN;

        // Reset defaults: attack 4800, no decay, release 24000, full scale.
        add_known(32'd0, 32'd10, 32'd0, 16'd0, 1'b0);            // before trigger
        add_known(32'd100, 32'd100, 32'd0, 16'd0, 1'b0);         // start of attack
        add_known(32'd4900, 32'd100, 32'd0, 16'd32768, 1'b0);    // end of attack
        add_known(32'hFFFF_FFFF, 32'd1, 32'd0, 16'd32768, 1'b0); // long sustain
        add_known(32'd0, 32'd0, 32'd0, 16'd0, 1'b0);             // released at trigger
        add_known(32'd4800, 32'd0, 32'd4800, 16'd32768, 1'b0);  // release instant
        add_known(32'd0, 32'd0, 32'd10000, 16'd32768, 1'b0);     // now before release
        add_known(32'd28800, 32'd0, 32'd4800, 16'd0, 1'b1);      // release complete
        add_known(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'd32768, 1'b0);
        add_known(32'd28798, 32'd0, 32'd4800, 16'd0, 1'b1);      // cut by the floor
        add_item(32'd28797, 32'd0, 32'd4800);                    // just above the floor
        add_item(32'd1000, 32'd0, 32'd500);                      // released during attack
        // Zero attack and zero release.
        add_cfg(CFG_ATTACK, '0);
        add_known(32'd5, 32'd5, 32'd0, 16'd32768, 1'b0);
        add_cfg(CFG_RELEASE, '0);
        add_known(32'd10, 32'd0, 32'd10, 16'd0, 1'b1);
        // Longest falling decay from a saturated start level.
        add_cfg(CFG_DECAY, TICKS_MAX);
        add_cfg(CFG_START, 18'h0FFFF);
        add_cfg(CFG_SUSTAIN, '0);
        add_cfg(CFG_RELEASE, TICKS_MAX);
        add_known(32'd7, 32'd7, 32'd0, 16'd32768, 1'b0);
        add_known(32'd262150, 32'd7, 32'd0, 16'd0, 1'b0);
        add_item(32'd131078, 32'd7, 32'd0);
        add_item(32'd200000, 32'd0, 32'd100000);                 // released mid-decay
        // Rising decay toward a saturated sustain level after the longest attack.
        add_cfg(CFG_START, 18'd100);
        add_cfg(CFG_SUSTAIN, 18'd40000);
        add_cfg(CFG_ATTACK, TICKS_MAX);
        add_item(32'd131072, 32'd1, 32'd0);
        add_item(32'd263144, 32'd1, 32'd0);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_item(32'hFFFF_FFFF, 32'd0, 32'd1000000);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table.
        directed_items = 0;
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG) begin
                wait_drained();
                cfg_write(directed_steps[i].idx, directed_steps[i].value);
                settings_used++;
            end else begin
                send_item(directed_steps[i].now_t, directed_steps[i].on_t,
                          directed_steps[i].off_t, directed_steps[i].fixed,
                          directed_steps[i].result);
                directed_items++;
            end
        end

        // Random phases, each with its own settings and idle/stall mix.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            if (phase == 0) begin
                cfg_write(CFG_ATTACK, TICKS_MAX);
                cfg_write(CFG_DECAY, TICKS_MAX);
                cfg_write(CFG_RELEASE, TICKS_MAX);
                cfg_write(CFG_START, 18'h0FFFF);
                cfg_write(CFG_SUSTAIN, 18'h0FFFF);
            end else if (phase == 1) begin
                cfg_write(CFG_ATTACK, '0);
                cfg_write(CFG_DECAY, '0);
                cfg_write(CFG_RELEASE, '0);
                cfg_write(CFG_START, '0);
                cfg_write(CFG_SUSTAIN, '0);
            end else begin
                cfg_write(CFG_ATTACK, pick_ticks());
                cfg_write(CFG_DECAY, pick_ticks());
                cfg_write(CFG_RELEASE, pick_ticks());
                cfg_write(CFG_START, 18'(pick_level()));
                cfg_write(CFG_SUSTAIN, 18'(pick_level()));
            end
            settings_used++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Let the pipeline empty completely once in the middle of each phase.
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random_item();
            end
        end

        // Drain and allow for any stray output after the last result.
        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d envelope transactions (%0d from the directed table),",
                 items_sent, directed_items);
        $display("checked %0d results over %0d register settings and four idle mixes.",
                 results_seen, settings_used);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
